// ===== design/akr_pkg.sv =====
// Shared types, fixed-point helpers and geometry constants for the arm keypoint
// reprojection residual block. No dependencies.
`default_nettype none

package akr_pkg;

  localparam int FRAC           = 24;
  localparam int KEYPOINTS      = 4;
  localparam int NUM_JOINTS_DEF = 4;
  localparam int SERIES_TERMS   = 30;
  localparam int ANG_W          = 16;
  localparam int OBS_W          = 15;
  localparam int RES_W          = 20;
  localparam int NUM_OBS        = 2 * KEYPOINTS;
  localparam int OBS_IDX_W      = $clog2(NUM_OBS);
  localparam int CFG_IDX_W      = OBS_IDX_W + 1;
  localparam int QB             = 20;   // quotient bits; anything larger saturates
  localparam int DEN_W          = 43;   // depth (31 bits) times 4096
  localparam int REM_W          = 64;
  localparam int DIFF_W         = 23;

  typedef logic signed [31:0] q_t;      // Q24 geometry value
  typedef logic signed [63:0] wide_t;

  localparam longint ONE_L = 64'sd1 <<< FRAC;
  localparam q_t     ONE_Q = q_t'(ONE_L);
  localparam wide_t  HALF  = 64'sd1 <<< (FRAC - 1);

  localparam logic signed [RES_W-1:0] RES_MAX = 20'sh7FFFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 20'sh80000;

  function automatic longint d4(input longint n);
    return (n * ONE_L + (n >= 0 ? 64'sd5000 : -64'sd5000)) / 64'sd10000;
  endfunction

  function automatic longint d10(input longint n);
    return (n * ONE_L + (n >= 0 ? 64'sd5000000000 : -64'sd5000000000))
           / 64'sd10000000000;
  endfunction

  function automatic longint f16(input longint n);
    return (n * 64'sd65536 + (n >= 0 ? 64'sd50000000 : -64'sd50000000))
           / 64'sd100000000;
  endfunction

  localparam longint AXIS_W [KEYPOINTS][3] = '{
    '{0, 0, d4(10000)},
    '{d4(7071), d4(7071), 0},
    '{d4(7071), d4(7071), 0},
    '{d4(7071), d4(7071), 0}
  };
  localparam longint AXIS_V [KEYPOINTS][3] = '{
    '{d4(-2590), d4(-640), 0},
    '{d4(-2828), d4(2828), d4(2974)},
    '{d4(-2340), d4(2340), d4(6619)},
    '{d4(-2270), d4(2270), d4(10361)}
  };
  localparam longint HOME_T [KEYPOINTS][3] = '{
    '{d4(1128), d4(-3078), d4(4000)},
    '{d4(3705), d4(-5655), d4(3310)},
    '{d4(6352), d4(-8302), d4(3210)},
    '{d4(7975), d4(-9925), d4(3210)}
  };
  localparam longint CAM_ROT [3][3] = '{
    '{d10(64'sd331778311), d10(-64'sd692838459), d10(-64'sd9968911764)},
    '{d10(64'sd9992971261), d10(64'sd83944406), d10(64'sd326725613)},
    '{d10(64'sd61063252), d10(-64'sd9975410330), d10(64'sd695322358)}
  };
  localparam longint CAM_POS [3] = '{
    d10(64'sd20950551217), d10(-64'sd1358101833), d10(64'sd1865990782)
  };
  localparam longint FOCAL  [2] = '{f16(64'sd91866857910), f16(64'sd91841821289)};
  localparam longint CENTRE [2] = '{f16(64'sd63938970947), f16(64'sd36101498413)};

  // Q24 product, rounded half away from zero
  function automatic q_t mulq(input q_t a, input q_t b);
    wide_t p;
    wide_t r;
    p = a * b;
    if (p >= 0) r = (p + HALF) >>> FRAC;
    else        r = -((-p + HALF) >>> FRAC);
    return r[31:0];
  endfunction

  function automatic wide_t mul_full(input q_t a, input q_t b);
    wide_t p;
    p = a * b;
    return p;
  endfunction

  // skew matrix of joint axis k
  function automatic q_t skew(input int k, input int i, input int j);
    q_t w0, w1, w2, r;
    w0 = q_t'(AXIS_W[k][0]);
    w1 = q_t'(AXIS_W[k][1]);
    w2 = q_t'(AXIS_W[k][2]);
    r  = '0;
    if (i == 0 && j == 1) r = -w2;
    if (i == 0 && j == 2) r = w1;
    if (i == 1 && j == 0) r = w2;
    if (i == 1 && j == 2) r = -w0;
    if (i == 2 && j == 0) r = -w1;
    if (i == 2 && j == 1) r = w0;
    return r;
  endfunction

  function automatic q_t skew2(input int k, input int i, input int j);
    q_t acc;
    acc = '0;
    for (int q = 0; q < 3; q++) acc = acc + mulq(skew(k, i, q), skew(k, q, j));
    return acc;
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [DIFF_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > DIFF_W'(RES_MAX))      r = RES_MAX;
    else if (v < DIFF_W'(RES_MIN)) r = RES_MIN;
    else                           r = v[RES_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/akr_sincos_cell.sv =====
// One Taylor-series cell of the sine/cosine chain: multiply, divide by term index,
// accumulate. Depends on akr_pkg.
`default_nettype none

module akr_sincos_cell #(
  parameter int LANES  = akr_pkg::NUM_JOINTS_DEF,
  parameter int TERM_N = 1
) (
  input  logic        clk,
  input  logic        en,
  input  akr_pkg::q_t a_i [LANES],
  input  akr_pkg::q_t t_i [LANES],
  input  akr_pkg::q_t s_i [LANES],
  input  akr_pkg::q_t c_i [LANES],
  output akr_pkg::q_t a_o [LANES],
  output akr_pkg::q_t t_o [LANES],
  output akr_pkg::q_t s_o [LANES],
  output akr_pkg::q_t c_o [LANES]
);

  localparam int PHASE = TERM_N % 4;
  // exact truncating divide by TERM_N for magnitudes up to 2^31: multiply by
  // floor(2^(32+l)/n)+1 and shift right by 32+l, l = ceil(log2 n)
  localparam int          LOG_N = $clog2(TERM_N);
  localparam int          SHIFT = 32 + LOG_N;
  localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / TERM_N + 1);

  akr_pkg::q_t p_r [LANES];
  akr_pkg::q_t pa_r [LANES], ps_r [LANES], pc_r [LANES];
  akr_pkg::q_t a_r [LANES], t_r [LANES], s_r [LANES], c_r [LANES];
  akr_pkg::q_t t_nxt [LANES], s_nxt [LANES], c_nxt [LANES];

  // first half: product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        p_r[l]  <= akr_pkg::mulq(t_i[l], a_i[l]);
        pa_r[l] <= a_i[l];
        ps_r[l] <= s_i[l];
        pc_r[l] <= c_i[l];
      end
    end
  end

  // second half: divide toward zero, add to or subtract from sine or cosine
  always_comb begin
    logic [31:0] mag;
    logic [64:0] prod;
    logic [31:0] qm;
    for (int l = 0; l < LANES; l++) begin
      mag      = p_r[l][31] ? 32'(-p_r[l]) : 32'(p_r[l]);
      prod     = 65'(RECIP) * 65'(mag);
      qm       = 32'(prod >> SHIFT);
      t_nxt[l] = p_r[l][31] ? -akr_pkg::q_t'(qm) : akr_pkg::q_t'(qm);
      s_nxt[l] = ps_r[l];
      c_nxt[l] = pc_r[l];
      case (PHASE)
        1:       s_nxt[l] = ps_r[l] + t_nxt[l];
        2:       c_nxt[l] = pc_r[l] - t_nxt[l];
        3:       s_nxt[l] = ps_r[l] - t_nxt[l];
        default: c_nxt[l] = pc_r[l] + t_nxt[l];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= pa_r;
      t_r <= t_nxt;
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  assign a_o = a_r;
  assign t_o = t_r;
  assign s_o = s_r;
  assign c_o = c_r;

endmodule

`default_nettype wire

// ===== design/akr_div_cell.sv =====
// One restoring-division cell: settles one quotient bit per lane per cycle while en is high.
// Depends on akr_pkg.
`default_nettype none

module akr_div_cell #(
  parameter int LANES  = 2 * akr_pkg::NUM_JOINTS_DEF,
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [akr_pkg::REM_W-1:0]  rem_i [LANES],
  input  logic [akr_pkg::DEN_W-1:0]  den_i [LANES],
  input  logic [akr_pkg::QB-1:0]     q_i   [LANES],
  input  logic [SIDE_W-1:0]          side_i,
  output logic [akr_pkg::REM_W-1:0]  rem_o [LANES],
  output logic [akr_pkg::DEN_W-1:0]  den_o [LANES],
  output logic [akr_pkg::QB-1:0]     q_o   [LANES],
  output logic [SIDE_W-1:0]          side_o
);

  logic [akr_pkg::REM_W-1:0] rem_r [LANES], rem_nxt [LANES];
  logic [akr_pkg::DEN_W-1:0] den_r [LANES];
  logic [akr_pkg::QB-1:0]    q_r   [LANES], q_nxt [LANES];
  logic [SIDE_W-1:0]         side_r;

  always_comb begin
    logic [akr_pkg::REM_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial      = akr_pkg::REM_W'(den_i[l]) << BIT;
      rem_nxt[l] = rem_i[l];
      q_nxt[l]   = q_i[l];
      if (rem_i[l] >= trial) begin
        rem_nxt[l]  = rem_i[l] - trial;
        q_nxt[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// ===== design/arm_keypoint_reprojection_residual.sv =====
// Path from input word to output word: angle register, 30 Taylor cells (product and sum
//   registers each), the joint chain, projection and 20 divider cells.
// Throughput: one word per cycle while the output is not stalled; each stage holds one word.
// Reset (rst_n low, synchronous): pipeline emptied, output invalid, observed pixels 0.
// Top level of the arm keypoint reprojection residual block. Uses akr_pkg,
// akr_sincos_cell and akr_div_cell.
`default_nettype none

module arm_keypoint_reprojection_residual #(
  parameter int NUM_JOINTS = akr_pkg::NUM_JOINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input: angle_one [15:0], angle_two [31:16], angle_three [47:32], angle_four [63:48]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [4*akr_pkg::ANG_W-1:0]     in_tdata,
  // output: res_u1 [19:0], res_v1, res_u2, res_v2, res_u3, res_v3, res_u4, res_v4 [159:140]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [8*akr_pkg::RES_W-1:0]     out_tdata,
  // tuser: depth_ok [0]
  output logic                            out_tuser,
  // observed pixel registers obs_u1..obs_v4 at index 0..7
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [akr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akr_pkg::OBS_W-1:0]       cfg_data
);

  localparam int JU  = (NUM_JOINTS < akr_pkg::KEYPOINTS) ? NUM_JOINTS : akr_pkg::KEYPOINTS;
  localparam int L2  = 2 * JU;
  localparam int NT  = akr_pkg::SERIES_TERMS;
  localparam int QB  = akr_pkg::QB;
  localparam int SW  = 5 * JU;   // side bits: depth positive, sign, overflow
  localparam int LAT = 1 + 2 * NT + 2 + (JU - 1) + 4 + QB + 1;

  typedef akr_pkg::q_t q_t;

  // ---------------------------------------------------------------- control
  // Whole pipeline moves together; it only holds when the last stage carries a
  // word, the output register is still occupied and out_tready is low.
  logic [LAT-1:0] v_r;
  logic           en;
  logic           out_tvalid_r;

  assign en        = !v_r[LAT-1] || !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en) v_r <= {v_r[LAT-2:0], in_tvalid};
      if (en && v_r[LAT-1]) out_tvalid_r <= 1'b1;
      else if (out_tready)  out_tvalid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- config
  logic [akr_pkg::OBS_W-1:0] obs_r [akr_pkg::NUM_OBS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_r <= '{default: '0};
    end else if (cfg_valid && cfg_index < akr_pkg::CFG_IDX_W'(akr_pkg::NUM_OBS)) begin
      obs_r[cfg_index[akr_pkg::OBS_IDX_W-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- angles
  // Q3.13 widened to Q24
  q_t a0_r [JU];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < JU; k++)
        a0_r[k] <= q_t'($signed(in_tdata[k*akr_pkg::ANG_W +: akr_pkg::ANG_W])) <<< 11;
    end
  end

  // ---------------------------------------------------------------- sin/cos row
  // Each cell adds one series term; cell n divides by n.
  q_t sc_a [NT+1][JU];
  q_t sc_t [NT+1][JU];
  q_t sc_s [NT+1][JU];
  q_t sc_c [NT+1][JU];

  for (genvar k = 0; k < JU; k++) begin : g_seed
    assign sc_a[0][k] = a0_r[k];
    assign sc_t[0][k] = akr_pkg::ONE_Q;
    assign sc_s[0][k] = '0;
    assign sc_c[0][k] = akr_pkg::ONE_Q;
  end

  for (genvar n = 1; n <= NT; n++) begin : g_sc
    akr_sincos_cell #(.LANES(JU), .TERM_N(n)) u_cell (
      .clk (clk),
      .en  (en),
      .a_i (sc_a[n-1]),
      .t_i (sc_t[n-1]),
      .s_i (sc_s[n-1]),
      .c_i (sc_c[n-1]),
      .a_o (sc_a[n]),
      .t_o (sc_t[n]),
      .s_o (sc_s[n]),
      .c_o (sc_c[n])
    );
  end

  // ---------------------------------------------------------------- joint exponentials
  // rotation R and translation operator M per joint
  q_t g1_r_r [JU][3][3], g1_r_nxt [JU][3][3];
  q_t g1_m_r [JU][3][3], g1_m_nxt [JU][3][3];

  always_comb begin
    q_t omc, tms, s, a;
    for (int k = 0; k < JU; k++) begin
      s   = sc_s[NT][k];
      a   = sc_a[NT][k];
      omc = akr_pkg::ONE_Q - sc_c[NT][k];
      tms = a - s;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          g1_r_nxt[k][i][j] = ((i == j) ? akr_pkg::ONE_Q : q_t'(0))
                            + akr_pkg::mulq(s, akr_pkg::skew(k, i, j))
                            + akr_pkg::mulq(omc, akr_pkg::skew2(k, i, j));
          g1_m_nxt[k][i][j] = ((i == j) ? a : q_t'(0))
                            + akr_pkg::mulq(omc, akr_pkg::skew(k, i, j))
                            + akr_pkg::mulq(tms, akr_pkg::skew2(k, i, j));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r_r <= g1_r_nxt;
      g1_m_r <= g1_m_nxt;
    end
  end

  // ---------------------------------------------------------------- chain
  // Stage 0 holds each joint's R and t = M v. Stage c turns slot c into the
  // accumulated pose E1..Ec using slot c-1; later slots ride along unchanged.
  q_t ch_m_r [JU][JU][3][3], ch_m_nxt [JU][JU][3][3];
  q_t ch_v_r [JU][JU][3],    ch_v_nxt [JU][JU][3];

  always_comb begin
    q_t acc;
    for (int k = 0; k < JU; k++) begin
      for (int i = 0; i < 3; i++) begin
        acc = '0;
        for (int j = 0; j < 3; j++) begin
          ch_m_nxt[0][k][i][j] = g1_r_r[k][i][j];
          acc = acc + akr_pkg::mulq(g1_m_r[k][i][j], q_t'(akr_pkg::AXIS_V[k][j]));
        end
        ch_v_nxt[0][k][i] = acc;
      end
    end
    for (int c = 1; c < JU; c++) begin
      ch_m_nxt[c] = ch_m_r[c-1];
      ch_v_nxt[c] = ch_v_r[c-1];
      for (int i = 0; i < 3; i++) begin
        acc = ch_v_r[c-1][c-1][i];
        for (int j = 0; j < 3; j++) begin
          acc = acc + akr_pkg::mulq(ch_m_r[c-1][c-1][i][j], ch_v_r[c-1][c][j]);
          ch_m_nxt[c][c][i][j] = '0;
          for (int q = 0; q < 3; q++)
            ch_m_nxt[c][c][i][j] = ch_m_nxt[c][c][i][j]
              + akr_pkg::mulq(ch_m_r[c-1][c-1][i][q], ch_m_r[c-1][c][q][j]);
        end
        ch_v_nxt[c][c][i] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_m_r <= ch_m_nxt;
      ch_v_r <= ch_v_nxt;
    end
  end

  // ---------------------------------------------------------------- positions
  q_t d_r [JU][3], d_nxt [JU][3];

  always_comb begin
    q_t acc;
    for (int k = 0; k < JU; k++) begin
      for (int i = 0; i < 3; i++) begin
        acc = ch_v_r[JU-1][k][i];
        for (int j = 0; j < 3; j++)
          acc = acc + akr_pkg::mulq(ch_m_r[JU-1][k][i][j], q_t'(akr_pkg::HOME_T[k][j]));
        d_nxt[k][i] = acc - q_t'(akr_pkg::CAM_POS[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  // camera frame: Rc^T (p - tc)
  q_t cam_r [JU][3], cam_nxt [JU][3];

  always_comb begin
    for (int k = 0; k < JU; k++) begin
      for (int i = 0; i < 3; i++) begin
        cam_nxt[k][i] = '0;
        for (int j = 0; j < 3; j++)
          cam_nxt[k][i] = cam_nxt[k][i]
                        + akr_pkg::mulq(q_t'(akr_pkg::CAM_ROT[j][i]), d_r[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) cam_r <= cam_nxt;
  end

  // ---------------------------------------------------------------- projection numerators
  akr_pkg::wide_t num_r [L2], num_nxt [L2];
  q_t             z_r [JU];

  always_comb begin
    for (int k = 0; k < JU; k++) begin
      for (int h = 0; h < 2; h++)
        num_nxt[2*k+h] = akr_pkg::mul_full(q_t'(akr_pkg::FOCAL[h]), cam_r[k][h])
                       + akr_pkg::mul_full(q_t'(akr_pkg::CENTRE[h]), cam_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      for (int k = 0; k < JU; k++) z_r[k] <= cam_r[k][2];
    end
  end

  // ---------------------------------------------------------------- division setup
  // N = |num| + den/2 with den = Z*4096; a quotient that would need more than
  // QB bits is flagged and later saturates anyway.
  logic [akr_pkg::REM_W-1:0] p4_rem_r [L2], p4_rem_nxt [L2];
  logic [akr_pkg::DEN_W-1:0] p4_den_r [L2], p4_den_nxt [L2];
  logic [SW-1:0]             p4_side_r, p4_side_nxt;

  always_comb begin
    logic [akr_pkg::REM_W-1:0] mag;
    logic [akr_pkg::REM_W-1:0] nsum;
    logic                      pos;
    p4_side_nxt = '0;
    for (int k = 0; k < JU; k++) begin
      pos = (z_r[k] > 0);
      p4_side_nxt[k] = pos;
      for (int h = 0; h < 2; h++) begin
        mag  = num_r[2*k+h][63] ? akr_pkg::REM_W'(-num_r[2*k+h])
                                : akr_pkg::REM_W'(num_r[2*k+h]);
        nsum = mag + (akr_pkg::REM_W'(z_r[k][30:0]) << 11);
        p4_side_nxt[JU + 2*k + h] = num_r[2*k+h][63];
        if (pos) begin
          p4_rem_nxt[2*k+h] = nsum;
          p4_den_nxt[2*k+h] = {z_r[k][30:0], 12'b0};
          p4_side_nxt[JU + L2 + 2*k + h] =
            (nsum >= (akr_pkg::REM_W'({z_r[k][30:0], 12'b0}) << QB));
        end else begin
          p4_rem_nxt[2*k+h] = '0;
          p4_den_nxt[2*k+h] = akr_pkg::DEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_rem_r  <= p4_rem_nxt;
      p4_den_r  <= p4_den_nxt;
      p4_side_r <= p4_side_nxt;
    end
  end

  // ---------------------------------------------------------------- divider row
  logic [akr_pkg::REM_W-1:0] dv_rem  [QB+1][L2];
  logic [akr_pkg::DEN_W-1:0] dv_den  [QB+1][L2];
  logic [QB-1:0]             dv_q    [QB+1][L2];
  logic [SW-1:0]             dv_side [QB+1];

  assign dv_rem[0]  = p4_rem_r;
  assign dv_den[0]  = p4_den_r;
  assign dv_side[0] = p4_side_r;
  for (genvar l = 0; l < L2; l++) begin : g_q0
    assign dv_q[0][l] = '0;
  end

  for (genvar b = 0; b < QB; b++) begin : g_div
    akr_div_cell #(.LANES(L2), .BIT(QB - 1 - b), .SIDE_W(SW)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (dv_rem[b]),
      .den_i  (dv_den[b]),
      .q_i    (dv_q[b]),
      .side_i (dv_side[b]),
      .rem_o  (dv_rem[b+1]),
      .den_o  (dv_den[b+1]),
      .q_o    (dv_q[b+1]),
      .side_o (dv_side[b+1])
    );
  end

  // ---------------------------------------------------------------- residuals
  // Keypoint one is observed minus predicted, the rest predicted minus observed.
  // A keypoint behind the camera predicts pixel 0 and clears depth_ok.
  logic signed [akr_pkg::RES_W-1:0] res_r [akr_pkg::NUM_OBS], res_nxt [akr_pkg::NUM_OBS];
  logic                             ok_r, ok_nxt;

  always_comb begin
    logic [QB-1:0]                     qv;
    logic signed [QB+1:0]              pu;
    logic signed [akr_pkg::DIFF_W-1:0] ob, diff;
    logic                              pos;
    ok_nxt = 1'b1;
    for (int l = 0; l < akr_pkg::NUM_OBS; l++) res_nxt[l] = '0;
    for (int k = 0; k < JU; k++) begin
      pos = dv_side[QB][k];
      if (!pos) ok_nxt = 1'b0;
      for (int h = 0; h < 2; h++) begin
        qv = dv_side[QB][JU + L2 + 2*k + h] ? {QB{1'b1}} : dv_q[QB][2*k+h];
        pu = '0;
        if (pos) begin
          pu = dv_side[QB][JU + 2*k + h] ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
        end
        ob   = $signed({8'b0, obs_r[2*k+h]});
        diff = (k == 0) ? ob - akr_pkg::DIFF_W'(pu) : akr_pkg::DIFF_W'(pu) - ob;
        res_nxt[2*k+h] = akr_pkg::sat_res(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ok_r  <= ok_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [8*akr_pkg::RES_W-1:0] out_tdata_r;
  logic                        out_tuser_r;

  always_ff @(posedge clk) begin
    if (en && v_r[LAT-1]) begin
      for (int l = 0; l < akr_pkg::NUM_OBS; l++)
        out_tdata_r[l*akr_pkg::RES_W +: akr_pkg::RES_W] <= res_r[l];
      out_tuser_r <= ok_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------- checks
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0) && !out_tvalid_r)
    else $error("pipeline not empty after reset");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAT-1] && !en) |=> v_r[LAT-1])
    else $error("word lost from last stage while stalled");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[LAT-1]) |=> out_tvalid_r)
    else $error("finished word did not reach the output register");

endmodule

`default_nettype wire

// ===== tb/sv/arm_keypoint_reprojection_residual_tb.sv =====
// Regression bench for arm_keypoint_reprojection_residual: streams joint angle words,
// predicts the eight pixel residuals and the depth flag, checks every result word.
// Depends on akr_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

module arm_keypoint_reprojection_residual_tb;

  localparam int  LATENCY   = 91;
  localparam int  SETTLE    = LATENCY + 40;
  localparam longint Q_ONE  = 64'sd1 <<< 24;

  typedef struct packed {
    logic [7:0][akr_pkg::RES_W-1:0] res;
    logic                           depth_ok;
  } residual_t;

  // Prediction of the reprojection pipeline, plus the queue of residual words it owes.
  class residual_board;
    longint    jw[4][3], jv[4][3], home[4][3], crot[3][3], cpos[3], foc[2], ctr[2];
    logic [akr_pkg::OBS_W-1:0] obs_px[akr_pkg::NUM_OBS];
    residual_t owed[$];
    int        mismatches;

    function longint dec4(longint n);
      return (n * Q_ONE + (n >= 0 ? 64'sd5000 : -64'sd5000)) / 64'sd10000;
    endfunction
    function longint dec10(longint n);
      return (n * Q_ONE + (n >= 0 ? 64'sd5000000000 : -64'sd5000000000))
             / 64'sd10000000000;
    endfunction
    function longint fx16(longint n);
      return (n * 64'sd65536 + (n >= 0 ? 64'sd50000000 : -64'sd50000000))
             / 64'sd100000000;
    endfunction

    function new();
      longint w4[4][3], v4[4][3], h4[4][3];
      longint r10[3][3];
      w4 = '{'{0, 0, 10000}, '{7071, 7071, 0}, '{7071, 7071, 0}, '{7071, 7071, 0}};
      v4 = '{'{-2590, -640, 0}, '{-2828, 2828, 2974}, '{-2340, 2340, 6619},
             '{-2270, 2270, 10361}};
      h4 = '{'{1128, -3078, 4000}, '{3705, -5655, 3310}, '{6352, -8302, 3210},
             '{7975, -9925, 3210}};
      r10 = '{'{64'sd331778311, -64'sd692838459, -64'sd9968911764},
              '{64'sd9992971261, 64'sd83944406, 64'sd326725613},
              '{64'sd61063252, -64'sd9975410330, 64'sd695322358}};
      for (int k = 0; k < 4; k++)
        for (int i = 0; i < 3; i++) begin
          jw[k][i] = dec4(w4[k][i]);
          jv[k][i] = dec4(v4[k][i]);
          home[k][i] = dec4(h4[k][i]);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) crot[i][j] = dec10(r10[i][j]);
      cpos[0] = dec10(64'sd20950551217);
      cpos[1] = dec10(-64'sd1358101833);
      cpos[2] = dec10(64'sd1865990782);
      foc[0] = fx16(64'sd91866857910);
      foc[1] = fx16(64'sd91841821289);
      ctr[0] = fx16(64'sd63938970947);
      ctr[1] = fx16(64'sd36101498413);
      foreach (obs_px[i]) obs_px[i] = '0;
      mismatches = 0;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + (Q_ONE / 2)) >>> 24;
      return -((-p + (Q_ONE / 2)) >>> 24);
    endfunction

    function longint div_round(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function logic [akr_pkg::RES_W-1:0] clamp(longint v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[akr_pkg::RES_W-1:0];
    endfunction

    function void set_obs(int idx, logic [akr_pkg::OBS_W-1:0] val);
      if (idx < akr_pkg::NUM_OBS) obs_px[idx] = val;
    endfunction

    // forward kinematics, camera transform and projection for one angle set
    function residual_t predict(logic [4*akr_pkg::ANG_W-1:0] angles);
      residual_t rv;
      longint er[3][3], et[3], sk[3][3], sk2[3][3], r[3][3], m[3][3], t[3];
      longint nr[3][3], nt[3], p[3], d[3], cam[3];
      longint a, term, sv, cv, omc, tms, pu, pv, ru, rvv, den;
      rv = '0;
      rv.depth_ok = 1'b1;
      er = '{'{Q_ONE, 0, 0}, '{0, Q_ONE, 0}, '{0, 0, Q_ONE}};
      et = '{0, 0, 0};
      for (int k = 0; k < 4; k++) begin
        a = longint'($signed(angles[k*akr_pkg::ANG_W +: akr_pkg::ANG_W])) * 2048;
        sk = '{'{0, -jw[k][2], jw[k][1]}, '{jw[k][2], 0, -jw[k][0]},
               '{-jw[k][1], jw[k][0], 0}};
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            sk2[i][j] = 0;
            for (int q = 0; q < 3; q++) sk2[i][j] += qmul(sk[i][q], sk[q][j]);
          end
        term = Q_ONE; sv = 0; cv = Q_ONE;
        for (int n = 1; n <= 30; n++) begin
          term = qmul(term, a) / n;
          case (n % 4)
            1: sv += term;
            2: cv -= term;
            3: sv -= term;
            default: cv += term;
          endcase
        end
        omc = Q_ONE - cv;
        tms = a - sv;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            r[i][j] = (i == j ? Q_ONE : 0) + qmul(sv, sk[i][j]) + qmul(omc, sk2[i][j]);
            m[i][j] = (i == j ? a : 0) + qmul(omc, sk[i][j]) + qmul(tms, sk2[i][j]);
          end
        for (int i = 0; i < 3; i++) begin
          t[i] = 0;
          for (int j = 0; j < 3; j++) t[i] += qmul(m[i][j], jv[k][j]);
        end
        for (int i = 0; i < 3; i++) begin
          nt[i] = et[i];
          for (int j = 0; j < 3; j++) begin
            nt[i] += qmul(er[i][j], t[j]);
            nr[i][j] = 0;
            for (int q = 0; q < 3; q++) nr[i][j] += qmul(er[i][q], r[q][j]);
          end
        end
        et = nt;
        er = nr;
        for (int i = 0; i < 3; i++) begin
          p[i] = et[i];
          for (int j = 0; j < 3; j++) p[i] += qmul(er[i][j], home[k][j]);
          d[i] = p[i] - cpos[i];
        end
        for (int i = 0; i < 3; i++) begin
          cam[i] = 0;
          for (int j = 0; j < 3; j++) cam[i] += qmul(crot[j][i], d[j]);
        end
        pu = 0; pv = 0;
        if (cam[2] > 0) begin
          den = cam[2] * 4096;
          pu = div_round(foc[0] * cam[0] + ctr[0] * cam[2], den);
          pv = div_round(foc[1] * cam[1] + ctr[1] * cam[2], den);
        end else begin
          rv.depth_ok = 1'b0;
        end
        // first keypoint keeps observed minus predicted
        if (k == 0) begin
          ru  = longint'(obs_px[0]) - pu;
          rvv = longint'(obs_px[1]) - pv;
        end else begin
          ru  = pu - longint'(obs_px[2*k]);
          rvv = pv - longint'(obs_px[2*k+1]);
        end
        rv.res[2*k]   = clamp(ru);
        rv.res[2*k+1] = clamp(rvv);
      end
      return rv;
    endfunction

    function void note_angles(logic [4*akr_pkg::ANG_W-1:0] angles);
      owed.push_back(predict(angles));
    endfunction

    function void check_word(logic [8*akr_pkg::RES_W-1:0] data, logic flag);
      residual_t exp_w;
      bit bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h flag %b", data, flag);
        return;
      end
      exp_w = owed.pop_front();
      bad = 0;
      for (int i = 0; i < 8; i++)
        if (data[i*akr_pkg::RES_W +: akr_pkg::RES_W] !== exp_w.res[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("residual %0d: expected %0d actual %0d", i,
                     $signed(exp_w.res[i]),
                     $signed(data[i*akr_pkg::RES_W +: akr_pkg::RES_W]));
        end
      if (flag !== exp_w.depth_ok) begin
        bad = 1;
        if (mismatches < 10)
          $display("depth_ok: expected %b actual %b", exp_w.depth_ok, flag);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [4*akr_pkg::ANG_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [8*akr_pkg::RES_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid, cfg_ready;
  logic [akr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [akr_pkg::OBS_W-1:0] cfg_data;

  residual_board board;
  int src_idle, sink_stall;

  arm_keypoint_reprojection_residual uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_angles(in_tdata);
      if (out_tvalid && out_tready) board.check_word(out_tdata, out_tuser);
    end
  end

  // receiver backpressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= sink_stall);

  // leaves in_tvalid high after the accept; idling or drain() drops it
  task automatic send_angles(logic [4*akr_pkg::ANG_W-1:0] word);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_obs(int idx, logic [akr_pkg::OBS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= akr_pkg::CFG_IDX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_obs(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.owed.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [akr_pkg::ANG_W-1:0] rand_angle();
    int v;
    v = int'($urandom_range(51472)) - 25736;
    return v[akr_pkg::ANG_W-1:0];
  endfunction

  function automatic logic [4*akr_pkg::ANG_W-1:0] rand_word();
    logic [4*akr_pkg::ANG_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      // mostly full range, sometimes near zero
      if ($urandom_range(3) == 0)
        w[k*akr_pkg::ANG_W +: akr_pkg::ANG_W] =
          akr_pkg::ANG_W'(int'($urandom_range(512)) - 256);
      else w[k*akr_pkg::ANG_W +: akr_pkg::ANG_W] = rand_angle();
    end
    return w;
  endfunction

  function automatic logic [4*akr_pkg::ANG_W-1:0] pack4(int a0, int a1, int a2, int a3);
    return {a3[akr_pkg::ANG_W-1:0], a2[akr_pkg::ANG_W-1:0],
            a1[akr_pkg::ANG_W-1:0], a0[akr_pkg::ANG_W-1:0]};
  endfunction

  initial begin
    #8_000_000;
    $display("arm_keypoint_reprojection_residual regression: fail");
    $finish;
  end

  initial begin
    int pmax, pmix;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    src_idle = 0; sink_stall = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset observations, angle extremes and quarter turns
    pmax = 25736; pmix = 12868;
    send_angles(pack4(0, 0, 0, 0));
    send_angles(pack4(pmax, pmax, pmax, pmax));
    send_angles(pack4(-pmax, -pmax, -pmax, -pmax));
    send_angles(pack4(pmax, -pmax, pmax, -pmax));
    send_angles(pack4(-pmax, pmax, -pmax, pmax));
    send_angles(pack4(pmix, pmix, pmix, pmix));
    send_angles(pack4(-pmix, -pmix, -pmix, -pmix));
    send_angles(pack4(1, -1, 1, -1));
    send_angles(pack4(0, pmax, 0, -pmax));
    send_angles(pack4(pmix, 0, -pmix, 0));
    drain();

    // observed pixels at maximum, plus ignored writes to unused indexes
    for (int i = 0; i < akr_pkg::NUM_OBS; i++) write_obs(i, '1);
    write_obs(akr_pkg::NUM_OBS, 15'h1234);
    write_obs(2 * akr_pkg::NUM_OBS - 1, 15'h0555);
    send_angles(pack4(0, 0, 0, 0));
    send_angles(pack4(pmax, pmax, pmax, pmax));
    send_angles(pack4(-pmax, pmix, -pmix, pmax));
    send_angles(pack4(pmix, -pmax, pmax, -pmix));
    drain();

    // random phases: idle pattern and observation setting change per phase
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 53; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 53; end
        default: begin src_idle = 22; sink_stall = 22; end
      endcase
      for (int i = 0; i < akr_pkg::NUM_OBS; i++) begin
        if (ph == 3) write_obs(i, '0);
        else if (ph == 6) write_obs(i, '1);
        else write_obs(i, akr_pkg::OBS_W'($urandom));
      end
      for (int n = 0; n < 125; n++) begin
        // hold off once until the pipeline has delivered everything owed
        if (ph == 5 && n == 60) drain();
        send_angles(rand_word());
      end
      drain();
    end

    src_idle = 0; sink_stall = 0;
    drain();
    if (board.mismatches == 0 && board.owed.size() == 0)
      $display("arm_keypoint_reprojection_residual regression: pass");
    else
      $display("arm_keypoint_reprojection_residual regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
